// ----- rtl/bdl_pkg.sv -----
// Shared types and constants of the Bayer 2x2 demosaic with luma.
// Used by the front, queue, back and top modules; depends on nothing.

package bdl_pkg;

    // Register indexes of the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_HALF    = 2'd1;
    localparam logic [1:0] REG_WIDTH   = 2'd2;
    localparam logic [1:0] REG_HEIGHT  = 2'd3;

    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    // Window kinds: where red and blue sit, which diagonal holds green.
    localparam logic [1:0] WIN_RGGB = 2'd0;
    localparam logic [1:0] WIN_BGGR = 2'd1;
    localparam logic [1:0] WIN_GRBG = 2'd2;
    localparam logic [1:0] WIN_GBRG = 2'd3;

    // Mosaic phase codes.
    localparam logic [1:0] PAT_RGGB = 2'd0;
    localparam logic [1:0] PAT_BGGR = 2'd1;
    localparam logic [1:0] PAT_GBRG = 2'd2;

    // Luma weights: 0.3 / 0.59 / 0.11 scaled by 256 (half mode: red and blue by 512).
    localparam logic [7:0] LUMA_R_FULL = 8'd77;
    localparam logic [7:0] LUMA_G      = 8'd151;
    localparam logic [7:0] LUMA_B_FULL = 8'd28;
    localparam logic [7:0] LUMA_R_HALF = 8'd154;
    localparam logic [7:0] LUMA_B_HALF = 8'd56;

    // Job queue between front and back.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;
    localparam int unsigned QCW    = 3;

    typedef struct packed {
        logic [1:0]  pattern;
        logic        half;
        logic [12:0] width;
        logic [12:0] height;
    } t_cfg;

    // One input sample with its 2x2 window and the results it causes.
    // mask: bit 0 main window (or the half-mode block), bit 1 last column,
    // bit 2 last row, bit 3 bottom right corner.
    typedef struct packed {
        logic [7:0]  ul;
        logic [7:0]  ur;
        logic [7:0]  ll;
        logic [7:0]  lr;
        logic [12:0] y;
        logic [12:0] x;
        logic        half;
        logic [3:0]  mask;
    } t_job;

    function automatic logic [1:0] kind_of(input logic [1:0] pattern,
                                           input logic rpar, input logic cpar);
        logic [1:0] k;
        k = WIN_RGGB;
        unique case (pattern)
            PAT_BGGR: begin
                unique case ({rpar, cpar})
                    2'b00:   k = WIN_BGGR;
                    2'b01:   k = WIN_GBRG;
                    2'b10:   k = WIN_GRBG;
                    default: k = WIN_RGGB;
                endcase
            end
            PAT_GBRG: begin
                unique case ({rpar, cpar})
                    2'b00:   k = WIN_GBRG;
                    2'b01:   k = WIN_BGGR;
                    2'b10:   k = WIN_RGGB;
                    default: k = WIN_GRBG;
                endcase
            end
            default: begin
                // RGGB, and the unused code treated as RGGB
                unique case ({rpar, cpar})
                    2'b00:   k = WIN_RGGB;
                    2'b01:   k = WIN_GRBG;
                    2'b10:   k = WIN_GBRG;
                    default: k = WIN_BGGR;
                endcase
            end
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/bdl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first: a read and a write at the same address return the old data.

module bdl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bdl_front.sv -----
// Front end: accepts raw samples, tracks position, reads and writes the line store
// and hands a classified job to the queue. Uses bdl_pkg and bdl_ram.

module bdl_front #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bdl_pkg::t_cfg            i_cfg,
    input  logic                     i_tvalid,
    output logic                     o_tready,
    input  logic [7:0]               i_tdata,
    input  logic [bdl_pkg::QCW-1:0]  i_q_count,
    output logic                     o_push,
    output bdl_pkg::t_job            o_job
);

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

    logic [CW-1:0] r_col, n_col;
    logic [12:0]   r_row, n_row;
    logic [7:0]    r_left;
    logic [7:0]    r_ul;
    logic          r_s1_valid;
    bdl_pkg::t_job r_s1, n_s1;
    logic [7:0]    ram_rdata;

    logic          accept;
    logic [13:0]   w_ext, w_eff;
    logic [12:0]   h_eff;
    logic          wrap;
    logic [CW-1:0] x;
    logic [13:0]   y_inc;
    logic [12:0]   y;
    logic          last_col, last_row;
    logic [3:0]    mask;

    assign o_tready = (4'(i_q_count) + 4'(r_s1_valid)) < 4'(bdl_pkg::QDEPTH);
    assign accept   = i_tvalid && o_tready;

    always_comb begin
        w_ext = {1'b0, i_cfg.width};
        if (w_ext < 14'd2) begin
            w_eff = 14'd2;
        end else if (w_ext > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = w_ext;
        end
        h_eff = (i_cfg.height < 13'd2) ? 13'd2 : i_cfg.height;

        // restart the column, then the row, if the frame shrank under us
        wrap  = 14'(r_col) >= w_eff;
        x     = wrap ? '0 : r_col;
        y_inc = wrap ? 14'(r_row) + 14'd1 : 14'(r_row);
        y     = (y_inc >= 14'(h_eff)) ? 13'd0 : 13'(y_inc);

        last_col = 14'(x) == (w_eff - 14'd1);
        last_row = y == (h_eff - 13'd1);

        if (i_cfg.half) begin
            mask = {3'b000, y[0] & x[0]};
        end else begin
            mask[0] = (y != 13'd0) && (x != '0);
            mask[1] = (y != 13'd0) && last_col;
            mask[2] = last_row && (x != '0);
            mask[3] = last_row && last_col;
        end

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? 13'd0 : y + 13'd1;
        end else begin
            n_col = x + CW'(1);
            n_row = y;
        end

        n_s1      = '0;
        n_s1.ll   = r_left;
        n_s1.lr   = i_tdata;
        n_s1.y    = y;
        n_s1.x    = 13'(x);
        n_s1.half = i_cfg.half;
        n_s1.mask = mask;
    end

    // Line store: read the previous row at x before this sample overwrites it.
    bdl_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (x),
        .i_wdata (i_tdata),
        .i_re    (accept),
        .i_raddr (x),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= i_tdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        // this sample's upper right is the next sample's upper left
        if (r_s1_valid) begin
            r_ul <= ram_rdata;
        end
    end

    always_comb begin
        o_job    = r_s1;
        o_job.ul = r_ul;
        o_job.ur = ram_rdata;
    end

    assign o_push = r_s1_valid && (r_s1.mask != 4'b0000);

    a_half_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.half) |-> (r_s1.mask[3:1] == 3'b000))
        else $error("half-mode job carries edge results");

    a_col_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col) |=> (r_col == '0))
        else $error("column did not restart after last column");

endmodule

// ----- rtl/bdl_queue.sv -----
// Short job queue that decouples the front end from the result back end.
// Uses bdl_pkg for the job type and depth.

module bdl_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bdl_pkg::t_job           i_job,
    input  logic                    i_pop,
    output bdl_pkg::t_job           o_job,
    output logic                    o_valid,
    output logic [bdl_pkg::QCW-1:0] o_count
);

    bdl_pkg::t_job           r_mem [bdl_pkg::QDEPTH];
    logic [bdl_pkg::QAW-1:0] r_wp, r_rp;
    logic [bdl_pkg::QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + bdl_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + bdl_pkg::QAW'(1);
            end
            r_count <= r_count + bdl_pkg::QCW'(i_push) - bdl_pkg::QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_valid = r_count != '0;
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && (r_count == bdl_pkg::QCW'(bdl_pkg::QDEPTH))))
        else $error("job queue overflow");

endmodule

// ----- rtl/bdl_back.sv -----
// Back end: expands each job into its results, picks colors by window phase,
// computes luma in two registered steps and drives the output register. Uses bdl_pkg.

module bdl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_pattern,
    input  bdl_pkg::t_job i_q_job,
    input  logic          i_q_valid,
    output logic          o_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [55:0]   o_tdata,
    output logic          o_tlast
);

    bdl_pkg::t_job r_job;
    logic [3:0]    r_mask, n_mask;
    logic [3:0]    cur_bit, rest;
    logic          emit, free_slot;

    // window and place of the result being issued
    logic [7:0]  w_ul, w_ur, w_ll, w_lr;
    logic        rpar, cpar;
    logic [11:0] row, col;
    logic [1:0]  kind;
    logic [7:0]  sel_red, sel_blue;
    logic [8:0]  sel_gsum;

    logic        r_p1_valid;
    logic [7:0]  r_p1_red, r_p1_blue;
    logic [8:0]  r_p1_gsum;
    logic        r_p1_half, r_p1_last;
    logic [11:0] r_p1_row, r_p1_col;

    logic        r_p2_valid;
    logic [15:0] r_p2_pr, r_p2_pb;
    logic [16:0] r_p2_pg;
    logic [7:0]  r_p2_red, r_p2_green, r_p2_blue;
    logic        r_p2_half, r_p2_last;
    logic [11:0] r_p2_row, r_p2_col;

    logic        r_out_valid;
    logic [7:0]  r_out_red, r_out_green, r_out_blue, r_out_luma;
    logic [11:0] r_out_row, r_out_col;
    logic        r_out_last;

    logic        out_en, p2_en, p1_en;
    logic [8:0]  gop;
    logic [17:0] lsum;

    assign out_en = !r_out_valid || i_tready;
    assign p2_en  = !r_p2_valid || out_en;
    assign p1_en  = !r_p1_valid || p2_en;

    assign cur_bit   = r_mask & (~r_mask + 4'd1);
    assign rest      = r_mask & ~cur_bit;
    assign emit      = (r_mask != 4'b0000) && p1_en;
    assign free_slot = (r_mask == 4'b0000) || (emit && (rest == 4'b0000));
    assign o_pop     = free_slot && i_q_valid;

    always_comb begin
        if (o_pop) begin
            n_mask = i_q_job.mask;
        end else if (emit) begin
            n_mask = rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_comb begin
        w_ul = r_job.ul;
        w_ur = r_job.ur;
        w_ll = r_job.ll;
        w_lr = r_job.lr;
        rpar = r_job.y[0] ^ 1'b1;
        cpar = r_job.x[0] ^ 1'b1;
        row  = 12'(r_job.y - 13'd1);
        col  = 12'(r_job.x - 13'd1);
        priority if (r_job.half) begin
            rpar = 1'b0;
            cpar = 1'b0;
            row  = r_job.y[12:1];
            col  = r_job.x[12:1];
        end else if (cur_bit[1]) begin
            // last column: right column repeats the left one
            w_ul = r_job.ur;
            w_ll = r_job.lr;
            cpar = r_job.x[0];
            col  = 12'(r_job.x);
        end else if (cur_bit[2]) begin
            // last row: lower row repeats the upper one
            w_ul = r_job.ll;
            w_ur = r_job.lr;
            rpar = r_job.y[0];
            row  = 12'(r_job.y);
        end else if (cur_bit[3]) begin
            w_ul = r_job.lr;
            w_ur = r_job.lr;
            w_ll = r_job.lr;
            rpar = r_job.y[0];
            cpar = r_job.x[0];
            row  = 12'(r_job.y);
            col  = 12'(r_job.x);
        end else begin
            w_ul = r_job.ul;
        end

        kind = bdl_pkg::kind_of(i_pattern, rpar, cpar);
        unique case (kind)
            bdl_pkg::WIN_RGGB: begin
                sel_red  = w_ul;
                sel_blue = w_lr;
                sel_gsum = 9'(w_ur) + 9'(w_ll);
            end
            bdl_pkg::WIN_BGGR: begin
                sel_red  = w_lr;
                sel_blue = w_ul;
                sel_gsum = 9'(w_ur) + 9'(w_ll);
            end
            bdl_pkg::WIN_GRBG: begin
                sel_red  = w_ur;
                sel_blue = w_ll;
                sel_gsum = 9'(w_ul) + 9'(w_lr);
            end
            default: begin
                sel_red  = w_ll;
                sel_blue = w_ur;
                sel_gsum = 9'(w_ul) + 9'(w_lr);
            end
        endcase
    end

    assign gop  = r_p1_half ? r_p1_gsum : {1'b0, r_p1_gsum[8:1]};
    assign lsum = 18'(r_p2_pr) + 18'(r_p2_pg) + 18'(r_p2_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (p1_en) begin
                r_p1_valid <= r_mask != 4'b0000;
            end
            if (p2_en) begin
                r_p2_valid <= r_p1_valid;
            end
            if (out_en) begin
                r_out_valid <= r_p2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_p1_red  <= sel_red;
            r_p1_blue <= sel_blue;
            r_p1_gsum <= sel_gsum;
            r_p1_half <= r_job.half;
            r_p1_last <= rest == 4'b0000;
            r_p1_row  <= row;
            r_p1_col  <= col;
        end
        if (p2_en && r_p1_valid) begin
            r_p2_pr    <= 16'(r_p1_red) * (r_p1_half ? 16'(bdl_pkg::LUMA_R_HALF)
                                                     : 16'(bdl_pkg::LUMA_R_FULL));
            r_p2_pb    <= 16'(r_p1_blue) * (r_p1_half ? 16'(bdl_pkg::LUMA_B_HALF)
                                                      : 16'(bdl_pkg::LUMA_B_FULL));
            r_p2_pg    <= 17'(gop) * 17'(bdl_pkg::LUMA_G);
            r_p2_red   <= r_p1_red;
            r_p2_green <= r_p1_gsum[8:1];
            r_p2_blue  <= r_p1_blue;
            r_p2_half  <= r_p1_half;
            r_p2_last  <= r_p1_last;
            r_p2_row   <= r_p1_row;
            r_p2_col   <= r_p1_col;
        end
        if (out_en && r_p2_valid) begin
            r_out_red   <= r_p2_red;
            r_out_green <= r_p2_green;
            r_out_blue  <= r_p2_blue;
            r_out_luma  <= r_p2_half ? lsum[16:9] : lsum[15:8];
            r_out_row   <= r_p2_row;
            r_out_col   <= r_p2_col;
            r_out_last  <= r_p2_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_col, r_out_row, r_out_luma, r_out_blue, r_out_green, r_out_red};
    assign o_tlast  = r_out_last;

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_tready && !r_out_last) |=>
        (r_out_valid || r_p2_valid || r_p1_valid || (r_mask != 4'b0000)))
        else $error("run ended without a last beat");

    a_half_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && r_p1_half) |-> r_p1_last)
        else $error("half-mode result not marked last");

endmodule

// ----- rtl/bayer_demosaic_luma.sv -----
// Bayer 2x2 demosaic with luma. Results pass the front, queue, job, select, product
// and output registers. Throughput: one sample per cycle while the queue has room; a
// last-column sample gives 2 results, a last-row sample 2 (4 at the corner), and the
// back end issues one result per cycle unless stalled, so bursts are paced by it.
// Reset (synchronous, active low) clears position, queue, pipeline and registers to
// their reset values; the line store is not cleared and needs no clearing pass.

module bayer_demosaic_luma #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // raw sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // raw_pixel[7:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16], luma[31:24],
                                        // out_row[43:32], out_col[55:44]
    output logic        m_axis_tlast    // last result caused by one input beat
);

    bdl_pkg::t_cfg           r_cfg;
    logic                    cfg_write;
    logic                    q_push, q_pop, q_valid;
    bdl_pkg::t_job           front_job, q_job;
    logic [bdl_pkg::QCW-1:0] q_count;

    // Registers: write on the access phase; pready is always high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= bdl_pkg::PAT_RGGB;
            r_cfg.half    <= 1'b0;
            r_cfg.width   <= bdl_pkg::WIDTH_RESET;
            r_cfg.height  <= bdl_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                bdl_pkg::REG_PATTERN: r_cfg.pattern <= pwdata[1:0];
                bdl_pkg::REG_HALF:    r_cfg.half    <= pwdata[0];
                bdl_pkg::REG_WIDTH:   r_cfg.width   <= pwdata[12:0];
                default:              r_cfg.height  <= pwdata[12:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bdl_pkg::REG_PATTERN: prdata = 32'(r_cfg.pattern);
            bdl_pkg::REG_HALF:    prdata = 32'(r_cfg.half);
            bdl_pkg::REG_WIDTH:   prdata = 32'(r_cfg.width);
            default:              prdata = 32'(r_cfg.height);
        endcase
    end

    // Front: position tracking and line store; it holds off input beats
    // when the queue has no room for what is already in flight.
    bdl_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_job     (front_job)
    );

    // Queue: absorb edge bursts so the input keeps flowing.
    bdl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    // Back: expand jobs into results, one per unstalled cycle, and drive the output register.
    bdl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pattern (r_cfg.pattern),
        .i_q_job   (q_job),
        .i_q_valid (q_valid),
        .o_pop     (q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for bayer_demosaic_luma: raw frames in, RGB plus luma out.
// Needs bdl_pkg (register indexes, mosaic and window codes) and the block itself.

module tb;

    localparam int          LINE_DEPTH = 4096;  // line store depth of the block
    localparam int          DRAIN      = 16;    // cycles to let a silent last beat retire
    localparam logic [1:0]  PAT_SPARE  = 2'd3;  // unused mosaic code, acts as RGGB

    // How directed frames fill their pixels.
    localparam int PIX_RANDOM  = 0;
    localparam int PIX_CHECKER = 1;
    localparam int PIX_FULL    = 2;
    localparam int PIX_RAMP    = 3;

    // One result beat, unpacked.
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  luma;
        logic [11:0] row;
        logic [11:0] col;
        logic        last;
    } t_demosaic_pixel;

    // Tracks the block's raster position, line store and registers, and keeps the
    // color results every accepted raw beat should produce, oldest first.
    class rgb_luma_scoreboard;
        logic [7:0]      line_buf [LINE_DEPTH];
        logic [7:0]      left_px;
        int unsigned     row_pos;
        int unsigned     col_pos;
        logic [1:0]      pattern;
        logic            half;
        logic [12:0]     width;
        logic [12:0]     height;
        t_demosaic_pixel expected_pixels [$];
        int              mismatches;

        function void reset();
            foreach (line_buf[i]) line_buf[i] = '0;
            left_px  = '0;
            row_pos  = 0;
            col_pos  = 0;
            pattern  = bdl_pkg::PAT_RGGB;
            half     = 1'b0;
            width    = bdl_pkg::WIDTH_RESET;
            height   = bdl_pkg::HEIGHT_RESET;
            expected_pixels.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                bdl_pkg::REG_PATTERN: pattern = value[1:0];
                bdl_pkg::REG_HALF:    half    = value[0];
                bdl_pkg::REG_WIDTH:   width   = value[12:0];
                default:              height  = value[12:0];
            endcase
        endfunction

        // Phase of the 2x2 window whose upper left sample sits at (row, col).
        function logic [1:0] window_kind(int unsigned row, int unsigned col);
            logic [1:0] pat;
            pat = (pattern == PAT_SPARE) ? bdl_pkg::PAT_RGGB : pattern;
            case ({pat, row[0], col[0]})
                {bdl_pkg::PAT_RGGB, 2'b00}: return bdl_pkg::WIN_RGGB;
                {bdl_pkg::PAT_RGGB, 2'b01}: return bdl_pkg::WIN_GRBG;
                {bdl_pkg::PAT_RGGB, 2'b10}: return bdl_pkg::WIN_GBRG;
                {bdl_pkg::PAT_RGGB, 2'b11}: return bdl_pkg::WIN_BGGR;
                {bdl_pkg::PAT_BGGR, 2'b00}: return bdl_pkg::WIN_BGGR;
                {bdl_pkg::PAT_BGGR, 2'b01}: return bdl_pkg::WIN_GBRG;
                {bdl_pkg::PAT_BGGR, 2'b10}: return bdl_pkg::WIN_GRBG;
                {bdl_pkg::PAT_BGGR, 2'b11}: return bdl_pkg::WIN_RGGB;
                {bdl_pkg::PAT_GBRG, 2'b00}: return bdl_pkg::WIN_GBRG;
                {bdl_pkg::PAT_GBRG, 2'b01}: return bdl_pkg::WIN_BGGR;
                {bdl_pkg::PAT_GBRG, 2'b10}: return bdl_pkg::WIN_RGGB;
                default:                    return bdl_pkg::WIN_GRBG;
            endcase
        endfunction

        // Color and luma of one window; ul/ur upper row, ll/lr lower row.
        function t_demosaic_pixel window_pixel(logic [1:0] kind, logic [7:0] ul,
                                               logic [7:0] ur, logic [7:0] ll,
                                               logic [7:0] lr, int unsigned row,
                                               int unsigned col, logic halved);
            t_demosaic_pixel p;
            int unsigned     red, blue, gsum, luma;
            case (kind)
                bdl_pkg::WIN_RGGB: begin red = ul; blue = lr; gsum = ur + ll; end
                bdl_pkg::WIN_BGGR: begin red = lr; blue = ul; gsum = ur + ll; end
                bdl_pkg::WIN_GRBG: begin red = ur; blue = ll; gsum = ul + lr; end
                default:           begin red = ll; blue = ur; gsum = ul + lr; end
            endcase
            if (halved)
                luma = (154 * red + 151 * gsum + 56 * blue) >> 9;
            else
                luma = (77 * red + 151 * (gsum >> 1) + 28 * blue) >> 8;
            p.red   = red[7:0];
            p.green = gsum[8:1];
            p.blue  = blue[7:0];
            p.luma  = luma[7:0];
            p.row   = row[11:0];
            p.col   = col[11:0];
            p.last  = 1'b0;
            return p;
        endfunction

        // Note one accepted raw beat: queue what it completes, then advance.
        function void accept_raw(logic [7:0] px);
            int unsigned     w, h, x, y;
            logic [7:0]      ul, ur, up;
            bit              last_col, last_row;
            t_demosaic_pixel burst [$];
            w = width;
            h = height;
            if (w < 2) w = 2;
            if (w > LINE_DEPTH) w = LINE_DEPTH;
            if (h < 2) h = 2;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            x = col_pos;
            y = row_pos;
            last_col = (x == w - 1);
            last_row = (y == h - 1);
            ul = '0;
            ur = '0;
            if (x >= 1) begin
                ul = line_buf[x - 1];
                ur = line_buf[x];
            end
            if (half) begin
                if (y[0] && x[0])
                    burst.push_back(window_pixel(window_kind(0, 0), ul, ur, left_px, px,
                                                 y >> 1, x >> 1, 1'b1));
            end else begin
                if (y >= 1 && x >= 1)
                    burst.push_back(window_pixel(window_kind(y - 1, x - 1), ul, ur,
                                                 left_px, px, y - 1, x - 1, 1'b0));
                // right edge: repeat the left column
                if (y >= 1 && last_col) begin
                    up = line_buf[x];
                    burst.push_back(window_pixel(window_kind(y - 1, x), up, up, px, px,
                                                 y - 1, x, 1'b0));
                end
                // bottom edge: repeat the upper row
                if (last_row && x >= 1)
                    burst.push_back(window_pixel(window_kind(y, x - 1), left_px, px,
                                                 left_px, px, y, x - 1, 1'b0));
                if (last_row && last_col)
                    burst.push_back(window_pixel(window_kind(y, x), px, px, px, px,
                                                 y, x, 1'b0));
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) expected_pixels.push_back(burst[i]);

            // the store lags one sample so the previous row stays readable
            if (x >= 1) line_buf[x - 1] = left_px;
            if (last_col) line_buf[x] = px;
            left_px = px;
            if (last_col) begin
                col_pos = 0;
                row_pos = last_row ? 0 : y + 1;
            end else begin
                col_pos = x + 1;
            end
        endfunction

        function void compare_field(string name, int unsigned want, logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_pixel(t_demosaic_pixel got);
            t_demosaic_pixel want;
            if (expected_pixels.size() == 0) begin
                $error("result beat with nothing expected: row %0d col %0d",
                       got.row, got.col);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red",         want.red,   got.red);
            compare_field("green",       want.green, got.green);
            compare_field("blue",        want.blue,  got.blue);
            compare_field("luma",        want.luma,  got.luma);
            compare_field("out_row",     want.row,   got.row);
            compare_field("out_col",     want.col,   got.col);
            compare_field("last_of_run", want.last,  got.last);
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // raw_pixel[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // red[7:0], green[15:8], blue[23:16], luma[31:24],
                                       // out_row[43:32], out_col[55:44]
    logic        m_axis_tlast;         // last result of one raw beat

    rgb_luma_scoreboard sb;
    bit                 quiet     = 1'b0;  // no idling on either side
    int                 gap_odds  = 0;     // 0: sender never pauses; else 1 in 2n+1
    int                 ready_hold = 0;
    int                 raw_sent  = 0;

    bayer_demosaic_luma #(
        .MAX_WIDTH(LINE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: random ready runs mixed with random stalls; quiet keeps it ready.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (quiet || $urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 30);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold = $urandom_range(0, 11);
        end
    end

    // Check every result beat against the oldest expectation; sample pre-edge values.
    always @(posedge i_clk) begin
        t_demosaic_pixel got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.red   = m_axis_tdata[7:0];
            got.green = m_axis_tdata[15:8];
            got.blue  = m_axis_tdata[23:16];
            got.luma  = m_axis_tdata[31:24];
            got.row   = m_axis_tdata[43:32];
            got.col   = m_axis_tdata[55:44];
            got.last  = m_axis_tlast;
            sb.check_pixel(got);
        end
    end

    // Write one register: setup cycle, access cycle, then idle with psel low so the
    // next write never re-drives psel in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every expected result, then let a silent beat retire.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Offer one raw beat, maybe after a pause; hold valid high between beats.
    task automatic send_pixel(input logic [7:0] px);
        if (!quiet && gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.accept_raw(px);
        raw_sent++;
    endtask

    function automatic logic [7:0] pick_pixel(int style, int idx);
        case (style)
            PIX_CHECKER: return (idx % 2 == 1) ? 8'd255 : 8'd0;
            PIX_FULL:    return 8'd255;
            PIX_RAMP:    return 8'(idx * 61 + 17);
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Reprogram at a frame boundary with the block idle, then stream whole frames.
    task automatic run_phase(input logic [1:0] pattern, input logic half,
                             input int width, input int height, input int frames,
                             input int style);
        int cols, rows;
        cols = (width < 2) ? 2 : (width > LINE_DEPTH ? LINE_DEPTH : width);
        rows = (height < 2) ? 2 : height;
        settle();
        write_reg(bdl_pkg::REG_PATTERN, 32'(pattern));
        write_reg(bdl_pkg::REG_HALF,    32'(half));
        write_reg(bdl_pkg::REG_WIDTH,   32'(width));
        write_reg(bdl_pkg::REG_HEIGHT,  32'(height));
        for (int f = 0; f < frames; f++) begin
            gap_odds = $urandom_range(0, 3);
            for (int i = 0; i < cols * rows; i++)
                send_pixel(pick_pixel(style, i));
        end
    endtask

    initial begin
        int random_start;
        sb = new();
        sb.reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: checkerboard extremes with both edges and the corner, GBRG
        // half mode with distinct samples so blue must come from the blue site,
        // the spare pattern code with undersized width and height at full scale,
        // and a BGGR frame taller than it is wide.
        run_phase(bdl_pkg::PAT_RGGB, 1'b0, 3, 3, 1, PIX_CHECKER);
        run_phase(bdl_pkg::PAT_GBRG, 1'b1, 2, 2, 1, PIX_RAMP);
        run_phase(PAT_SPARE,         1'b0, 1, 0, 1, PIX_FULL);
        run_phase(bdl_pkg::PAT_BGGR, 1'b0, 2, 3, 1, PIX_RAMP);

        // Random small frames: every pattern and mode, odd sizes in half mode and
        // sizes below the minimum included.
        random_start = raw_sent;
        while (raw_sent - random_start < 140)
            run_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 8), $urandom_range(0, 5),
                      $urandom_range(1, 2), PIX_RANDOM);

        // Last part without idling: a small frame with both edges and the corner.
        quiet = 1'b1;
        run_phase(bdl_pkg::PAT_BGGR, 1'b0, 4, 3, 1, PIX_RANDOM);

        settle();
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #16000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
